// File: sv/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, codes and constants of the servo pose record/playback block.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int POSE_SLOTS_DEF = 4;
    localparam int NUM_LANES      = 4;
    localparam int READ_W         = 8;
    localparam int DUTY_W         = 9;
    localparam int POSE_W         = NUM_LANES * READ_W;

    typedef enum logic [1:0] {
        REQ_BUTTON,
        REQ_ANGLE,
        REQ_RECORD,
        REQ_TICK
    } t_req;

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_MANUAL,
        MODE_PLAYBACK,
        MODE_REMOTE
    } t_mode;

    typedef enum logic [1:0] {
        REP_NONE,
        REP_SLOT,
        REP_COUNT
    } t_report;

    typedef enum logic [1:0] {
        SRC_READING,
        SRC_POSE,
        SRC_ANGLE
    } t_src;

    localparam logic [3:0] BTN_MANUAL     = 4'd1;
    localparam logic [3:0] BTN_PLAY       = 4'd2;
    localparam logic [3:0] BTN_REMOTE     = 4'd3;
    localparam logic [7:0] BTN_VAL_SELECT = 8'd0;
    localparam logic [7:0] BTN_VAL_PLAY   = 8'd1;
    localparam logic [3:0] SERVO_FIRST    = 4'd1;
    localparam logic [3:0] SERVO_LAST     = 4'd4;

    // duty = OFF + r*MUL1/255, then optionally (that)*MUL2/255
    localparam logic [7:0] MAP_MUL1 [NUM_LANES] = '{8'd225, 8'd180, 8'd41, 8'd53};
    localparam logic [7:0] MAP_OFF  [NUM_LANES] = '{8'd75, 8'd120, 8'd214, 8'd74};
    localparam logic [7:0] MAP_MUL2 [NUM_LANES] = '{8'd0, 8'd0, 8'd77, 8'd75};
    localparam logic       MAP_TWO_STEP [NUM_LANES] = '{1'b0, 1'b0, 1'b1, 1'b1};

    // angle clamp ranges and span divisors
    localparam logic [7:0] ANG_LO [NUM_LANES] = '{8'd0, 8'd95, 8'd150, 8'd52};
    localparam logic [7:0] ANG_HI [NUM_LANES] = '{8'd180, 8'd180, 8'd180, 8'd85};
    localparam int         ANG_DIV [NUM_LANES] = '{180, 85, 30, 33};
    localparam logic [15:0] ANG_SCALE = 16'd255;
    localparam int         ANG_SHIFT = 23;
    localparam int         RECIP_W   = 19;
    localparam logic [RECIP_W-1:0] ANG_RECIP [NUM_LANES] = '{
        RECIP_W'((2**ANG_SHIFT + ANG_DIV[0] - 1) / ANG_DIV[0]),
        RECIP_W'((2**ANG_SHIFT + ANG_DIV[1] - 1) / ANG_DIV[1]),
        RECIP_W'((2**ANG_SHIFT + ANG_DIV[2] - 1) / ANG_DIV[2]),
        RECIP_W'((2**ANG_SHIFT + ANG_DIV[3] - 1) / ANG_DIV[3])
    };

    typedef struct packed {
        logic                 load;
        logic                 decode;
        t_src                 src;
        logic [NUM_LANES-1:0] mask;
        logic [1:0]           lane;
        logic                 mode_we;
        t_mode                mode_val;
        logic                 record;
        logic                 play;
        logic                 commit;
        logic                 advance;
        logic                 out_load;
    } t_cmd;

    typedef struct packed {
        t_req       req_type;
        logic [3:0] target;
        logic [7:0] value;
        t_mode      mode;
        logic       count_zero;
    } t_status;

    // floor(x/255), exact for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

// File: sv/servo_pose_record_playback.sv
// Sequence: mode, record and ignored items pass through decode and done; items
// that update duties pass through decode, the map pipeline, commit and done.
// The sequencer holds one item at a time.
// Reset: synchronous, active low; mode off, duties, slots and count cleared;
// the pose store is not cleared.
// ----------------------------------------------------------------------------
// servo_pose_record_playback
// Four-servo controller with manual, remote and pose record/playback modes.
// ----------------------------------------------------------------------------
module servo_pose_record_playback #(
    parameter int POSE_SLOTS = spr_pkg::POSE_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [3:0] i_target_number,
    input  logic [7:0] i_command_value,
    input  logic [7:0] i_reading_a,
    input  logic [7:0] i_reading_b,
    input  logic [7:0] i_reading_c,
    input  logic [7:0] i_reading_d,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [8:0] o_duty_a,
    output logic [8:0] o_duty_b,
    output logic [6:0] o_duty_c,
    output logic [5:0] o_duty_d,
    output logic [3:0] o_duty_changed,
    output logic [1:0] o_current_mode,
    output logic [1:0] o_report_kind,
    output logic [2:0] o_report_value
);
    import spr_pkg::*;

    t_cmd    cmd;
    t_status status;

    spr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    spr_dpath #(
        .POSE_SLOTS (POSE_SLOTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (i_req_type),
        .i_target_number (i_target_number),
        .i_command_value (i_command_value),
        .i_reading_a     (i_reading_a),
        .i_reading_b     (i_reading_b),
        .i_reading_c     (i_reading_c),
        .i_reading_d     (i_reading_d),
        .o_status        (status),
        .o_duty_a        (o_duty_a),
        .o_duty_b        (o_duty_b),
        .o_duty_c        (o_duty_c),
        .o_duty_d        (o_duty_d),
        .o_duty_changed  (o_duty_changed),
        .o_current_mode  (o_current_mode),
        .o_report_kind   (o_report_kind),
        .o_report_value  (o_report_value)
    );

endmodule

// File: sv/spr_ctrl.sv
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer: decodes each item and steps the datapath through its work.
// ----------------------------------------------------------------------------
module spr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  spr_pkg::t_status i_status,
    output spr_pkg::t_cmd    o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);
    import spr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MAP,
        ST_COMMIT,
        ST_DONE
    } t_state;

    localparam logic [2:0] MAP_LAST = 3'd4;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_play, n_play;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_play      = r_play;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                n_cnt      = '0;
                n_play     = 1'b0;
                n_state    = ST_DONE;
                unique case (i_status.req_type)
                    REQ_BUTTON: begin
                        if (i_status.target == BTN_MANUAL) begin
                            cmd.mode_we  = 1'b1;
                            cmd.mode_val = MODE_MANUAL;
                        end else if (i_status.target == BTN_REMOTE) begin
                            cmd.mode_we  = 1'b1;
                            cmd.mode_val = MODE_REMOTE;
                        end else if (i_status.target == BTN_PLAY &&
                                     i_status.value == BTN_VAL_SELECT) begin
                            cmd.mode_we  = 1'b1;
                            cmd.mode_val = MODE_PLAYBACK;
                        end else if (i_status.target == BTN_PLAY &&
                                     i_status.value == BTN_VAL_PLAY &&
                                     i_status.mode == MODE_PLAYBACK &&
                                     !i_status.count_zero) begin
                            cmd.play = 1'b1;
                            cmd.src  = SRC_POSE;
                            cmd.mask = '1;
                            n_play   = 1'b1;
                            n_state  = ST_MAP;
                        end
                    end
                    REQ_ANGLE: begin
                        if (i_status.mode == MODE_REMOTE &&
                            i_status.target >= SERVO_FIRST &&
                            i_status.target <= SERVO_LAST) begin
                            cmd.src  = SRC_ANGLE;
                            cmd.lane = i_status.target[1:0] - 2'd1;
                            cmd.mask = NUM_LANES'(1) << cmd.lane;
                            n_state  = ST_MAP;
                        end
                    end
                    REQ_RECORD: begin
                        cmd.record = (i_status.mode != MODE_PLAYBACK);
                    end
                    REQ_TICK: begin
                        if (i_status.mode == MODE_MANUAL) begin
                            cmd.src  = SRC_READING;
                            cmd.mask = '1;
                            n_state  = ST_MAP;
                        end
                    end
                    default: ;
                endcase
            end
            ST_MAP: begin
                if (r_cnt == MAP_LAST) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_COMMIT: begin
                cmd.commit  = 1'b1;
                cmd.advance = r_play;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_play      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_play      <= n_play;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: sv/spr_dpath.sv
// ----------------------------------------------------------------------------
// spr_dpath
// Datapath: item registers, pose ring, angle conversion and duty mapping.
// ----------------------------------------------------------------------------
module spr_dpath #(
    parameter int POSE_SLOTS = spr_pkg::POSE_SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spr_pkg::t_cmd    i_cmd,
    input  logic [1:0]       i_req_type,
    input  logic [3:0]       i_target_number,
    input  logic [7:0]       i_command_value,
    input  logic [7:0]       i_reading_a,
    input  logic [7:0]       i_reading_b,
    input  logic [7:0]       i_reading_c,
    input  logic [7:0]       i_reading_d,
    output spr_pkg::t_status o_status,
    output logic [8:0]       o_duty_a,
    output logic [8:0]       o_duty_b,
    output logic [6:0]       o_duty_c,
    output logic [5:0]       o_duty_d,
    output logic [3:0]       o_duty_changed,
    output logic [1:0]       o_current_mode,
    output logic [1:0]       o_report_kind,
    output logic [2:0]       o_report_value
);
    import spr_pkg::*;

    localparam int SLOT_W = $clog2(POSE_SLOTS);
    localparam int CNT_W  = $clog2(POSE_SLOTS + 1);
    localparam int PROD_W = 16 + RECIP_W;

    // item registers
    logic [1:0]           r_req_type;
    logic [3:0]           r_target;
    logic [7:0]           r_value;
    logic [READ_W-1:0]    r_rd [NUM_LANES];
    t_src                 r_src;
    logic [1:0]           r_lane;
    logic [NUM_LANES-1:0] r_changed;
    t_report              r_rkind;
    logic [2:0]           r_rval;

    // architectural state
    t_mode                r_mode;
    logic [DUTY_W-1:0]    r_duty [NUM_LANES];
    logic [SLOT_W-1:0]    r_write_slot;
    logic [SLOT_W-1:0]    r_read_slot;
    logic [CNT_W-1:0]     r_count;
    logic [POSE_W-1:0]    mem [POSE_SLOTS];
    logic [POSE_W-1:0]    r_pose_q;

    // mapping pipeline
    logic [15:0]          r_x;
    logic [READ_W-1:0]    r_ang;
    logic [15:0]          r_p1 [NUM_LANES];
    logic [DUTY_W-1:0]    r_s  [NUM_LANES];
    logic [15:0]          r_p2 [NUM_LANES];

    // output register
    logic [DUTY_W-1:0]    r_out_duty [NUM_LANES];
    logic [NUM_LANES-1:0] r_out_changed;
    t_mode                r_out_mode;
    t_report              r_out_kind;
    logic [2:0]           r_out_val;

    logic [7:0]           clamped;
    logic [7:0]           ang_d;
    logic [PROD_W-1:0]    ang_prod;
    logic [READ_W-1:0]    src [NUM_LANES];
    logic [DUTY_W-1:0]    duty_n [NUM_LANES];
    logic [CNT_W-1:0]     cnt_next;
    logic [CNT_W-1:0]     slot_p1;
    logic [CNT_W+2:0]     cnt_ext;
    logic [CNT_W+2:0]     slot_ext;

    assign o_status.req_type   = t_req'(r_req_type);
    assign o_status.target     = r_target;
    assign o_status.value      = r_value;
    assign o_status.mode       = r_mode;
    assign o_status.count_zero = (r_count == '0);

    always_comb begin
        if (r_value < ANG_LO[r_lane]) begin
            clamped = ANG_LO[r_lane];
        end else if (r_value > ANG_HI[r_lane]) begin
            clamped = ANG_HI[r_lane];
        end else begin
            clamped = r_value;
        end
        ang_d    = clamped - ANG_LO[r_lane];
        ang_prod = PROD_W'(r_x) * PROD_W'(ANG_RECIP[r_lane]);

        for (int k = 0; k < NUM_LANES; k++) begin
            case (r_src)
                SRC_POSE:  src[k] = r_pose_q[k*READ_W +: READ_W];
                SRC_ANGLE: src[k] = r_ang;
                default:   src[k] = r_rd[k];
            endcase
            duty_n[k] = MAP_TWO_STEP[k] ? DUTY_W'(div255(r_p2[k])) : r_s[k];
        end

        cnt_next = (r_count != CNT_W'(POSE_SLOTS)) ? r_count + CNT_W'(1) : r_count;
        slot_p1  = CNT_W'(r_read_slot) + CNT_W'(1);
        cnt_ext  = {3'b000, cnt_next};
        slot_ext = {3'b000, slot_p1};
    end

    // free-running mapping pipeline; the sequencer times the commit
    always_ff @(posedge i_clk) begin
        r_x      <= 16'(ang_d) * ANG_SCALE;
        r_ang    <= ang_prod[ANG_SHIFT +: READ_W];
        r_pose_q <= mem[r_read_slot];
        for (int k = 0; k < NUM_LANES; k++) begin
            r_p1[k] <= 16'(src[k]) * 16'(MAP_MUL1[k]);
            r_s[k]  <= DUTY_W'(MAP_OFF[k]) + DUTY_W'(div255(r_p1[k]));
            r_p2[k] <= 16'(r_s[k][7:0]) * 16'(MAP_MUL2[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_target   <= i_target_number;
            r_value    <= i_command_value;
            r_rd[0]    <= i_reading_a;
            r_rd[1]    <= i_reading_b;
            r_rd[2]    <= i_reading_c;
            r_rd[3]    <= i_reading_d;
        end
        if (i_cmd.decode) begin
            r_src     <= i_cmd.src;
            r_lane    <= i_cmd.lane;
            r_changed <= i_cmd.mask;
            if (i_cmd.record) begin
                r_rkind <= REP_COUNT;
                r_rval  <= cnt_ext[2:0];
            end else if (i_cmd.play) begin
                r_rkind <= REP_SLOT;
                r_rval  <= slot_ext[2:0];
            end else begin
                r_rkind <= REP_NONE;
                r_rval  <= '0;
            end
        end
        if (i_cmd.record) begin
            mem[r_write_slot] <= {r_rd[3], r_rd[2], r_rd[1], r_rd[0]};
        end
        if (i_cmd.out_load) begin
            r_out_duty    <= r_duty;
            r_out_changed <= r_changed;
            r_out_mode    <= r_mode;
            r_out_kind    <= r_rkind;
            r_out_val     <= r_rval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_OFF;
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_count      <= '0;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_duty[k] <= '0;
            end
        end else begin
            if (i_cmd.mode_we) begin
                r_mode <= i_cmd.mode_val;
            end
            if (i_cmd.record) begin
                r_count <= cnt_next;
                if (r_write_slot == SLOT_W'(POSE_SLOTS - 1)) begin
                    r_write_slot <= '0;
                end else begin
                    r_write_slot <= r_write_slot + SLOT_W'(1);
                end
            end
            if (i_cmd.advance) begin
                if (slot_p1 == r_count) begin
                    r_read_slot <= '0;
                end else begin
                    r_read_slot <= slot_p1[SLOT_W-1:0];
                end
            end
            if (i_cmd.commit) begin
                for (int k = 0; k < NUM_LANES; k++) begin
                    if (r_changed[k]) begin
                        r_duty[k] <= duty_n[k];
                    end
                end
            end
        end
    end

    assign o_duty_a       = r_out_duty[0];
    assign o_duty_b       = r_out_duty[1];
    assign o_duty_c       = r_out_duty[2][6:0];
    assign o_duty_d       = r_out_duty[3][5:0];
    assign o_duty_changed = r_out_changed;
    assign o_current_mode = r_out_mode;
    assign o_report_kind  = r_out_kind;
    assign o_report_value = r_out_val;

endmodule

// File: tb/servo_pose_record_playback_tb.sv
// ----------------------------------------------------------------------------
// servo_pose_record_playback_tb
// Self-checking bench for the four-servo pose record/playback controller.
// A queue of directed and scenario-based random items drives the input side.
// The output side is throttled at random, with one long hold that backs the
// block up. Each accepted item runs through an internal arm predictor. Every
// result is compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module servo_pose_record_playback_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spr_pkg::*;

    localparam int SLOTS          = POSE_SLOTS_DEF;
    localparam int RANDOM_ITEMS   = 1975;
    localparam int CALM_TAIL      = 200;
    localparam int HOLD_START     = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_PAUSE      = 20;
    localparam int MAX_PRINTS     = 40;

    localparam int ANGLE_MIN [4] = '{0, 95, 150, 52};
    localparam int ANGLE_MAX [4] = '{180, 180, 180, 85};

    typedef struct packed {
        t_req            kind;
        logic [3:0]      target;
        logic [7:0]      value;
        logic [3:0][7:0] rd;
    } t_arm_req;

    typedef struct packed {
        logic [8:0] duty_a;
        logic [8:0] duty_b;
        logic [6:0] duty_c;
        logic [5:0] duty_d;
        logic [3:0] changed;
        t_mode      mode;
        t_report    kind;
        logic [2:0] value;
    } t_arm_out;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic       i_out_stall     = 1'b0;
    logic [1:0] i_req_type      = '0;
    logic [3:0] i_target_number = '0;
    logic [7:0] i_command_value = '0;
    logic [7:0] i_reading_a     = '0;
    logic [7:0] i_reading_b     = '0;
    logic [7:0] i_reading_c     = '0;
    logic [7:0] i_reading_d     = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [8:0] o_duty_a;
    logic [8:0] o_duty_b;
    logic [6:0] o_duty_c;
    logic [5:0] o_duty_d;
    logic [3:0] o_duty_changed;
    logic [1:0] o_current_mode;
    logic [1:0] o_report_kind;
    logic [2:0] o_report_value;

    servo_pose_record_playback #(
        .POSE_SLOTS(SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_target_number(i_target_number),
        .i_command_value(i_command_value),
        .i_reading_a    (i_reading_a),
        .i_reading_b    (i_reading_b),
        .i_reading_c    (i_reading_c),
        .i_reading_d    (i_reading_d),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_duty_a       (o_duty_a),
        .o_duty_b       (o_duty_b),
        .o_duty_c       (o_duty_c),
        .o_duty_d       (o_duty_d),
        .o_duty_changed (o_duty_changed),
        .o_current_mode (o_current_mode),
        .o_report_kind  (o_report_kind),
        .o_report_value (o_report_value)
    );

    t_arm_req        req_q [$];
    t_arm_out        arm_out_q [$];

    t_mode           arm_mode;
    logic [8:0]      duty_now [4];
    logic [3:0][7:0] pose_mem [SLOTS];
    int              rec_slot;
    int              play_slot;
    int              pose_count;

    int items_total;
    int items_in;
    int results_out;
    int mismatches;
    int n_records;
    int n_replays;
    int n_angles;
    int n_ticks;
    int send_idle;
    int send_quiet;
    int stall_left;
    int stall_quiet;
    int hold_left;
    int run_cycles;
    int quiet_cycles;
    logic tail_calm = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [8:0] servo_duty(input int lane, input int r);
        int t;
        case (lane)
            0:       t = 75 + (r * 225) / 255;
            1:       t = 120 + (r * 180) / 255;
            2:       t = ((214 + (r * 41) / 255) * 77) / 255;
            default: t = ((74 + (r * 53) / 255) * 75) / 255;
        endcase
        return t[8:0];
    endfunction

    task automatic arm_step(input t_arm_req r, output t_arm_out o);
        logic [3:0] changed;
        t_report    kind;
        logic [2:0] rep;
        int         slot;
        int         lane;
        int         a;
        changed = '0;
        kind    = REP_NONE;
        rep     = '0;
        case (r.kind)
            REQ_BUTTON: begin
                if (r.target == BTN_MANUAL) begin
                    arm_mode = MODE_MANUAL;
                end else if (r.target == BTN_REMOTE) begin
                    arm_mode = MODE_REMOTE;
                end else if (r.target == BTN_PLAY && r.value == BTN_VAL_SELECT) begin
                    arm_mode = MODE_PLAYBACK;
                end else if (r.target == BTN_PLAY && r.value == BTN_VAL_PLAY &&
                             arm_mode == MODE_PLAYBACK && pose_count != 0) begin
                    slot = play_slot % SLOTS;
                    for (lane = 0; lane < 4; lane++)
                        duty_now[lane] = servo_duty(lane, pose_mem[slot][lane]);
                    changed   = 4'hF;
                    kind      = REP_SLOT;
                    rep       = 3'(slot + 1);
                    play_slot = (slot + 1) % pose_count;
                    n_replays++;
                end
            end
            REQ_ANGLE: begin
                if (arm_mode == MODE_REMOTE && r.target >= SERVO_FIRST &&
                    r.target <= SERVO_LAST) begin
                    lane = r.target - SERVO_FIRST;
                    a    = r.value;
                    if (a < ANGLE_MIN[lane]) a = ANGLE_MIN[lane];
                    if (a > ANGLE_MAX[lane]) a = ANGLE_MAX[lane];
                    duty_now[lane] = servo_duty(lane, ((a - ANGLE_MIN[lane]) * 255) /
                                                      (ANGLE_MAX[lane] - ANGLE_MIN[lane]));
                    changed[lane] = 1'b1;
                    n_angles++;
                end
            end
            REQ_RECORD: begin
                if (arm_mode != MODE_PLAYBACK) begin
                    pose_mem[rec_slot] = r.rd;
                    rec_slot = (rec_slot + 1) % SLOTS;
                    if (pose_count < SLOTS) pose_count++;
                    kind = REP_COUNT;
                    rep  = 3'(pose_count);
                    n_records++;
                end
            end
            default: begin
                if (arm_mode == MODE_MANUAL) begin
                    for (lane = 0; lane < 4; lane++)
                        duty_now[lane] = servo_duty(lane, r.rd[lane]);
                    changed = 4'hF;
                    n_ticks++;
                end
            end
        endcase
        o.duty_a  = duty_now[0];
        o.duty_b  = duty_now[1];
        o.duty_c  = duty_now[2][6:0];
        o.duty_d  = duty_now[3][5:0];
        o.changed = changed;
        o.mode    = arm_mode;
        o.kind    = kind;
        o.value   = rep;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] rand_pose();
        return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
    endfunction

    function automatic t_arm_req arm_req(input t_req k, input int tgt, input int val,
                                         input logic [31:0] rd);
        t_arm_req r;
        r.kind   = k;
        r.target = tgt[3:0];
        r.value  = val[7:0];
        r.rd     = rd;
        return r;
    endfunction

    function automatic int quiet_len();
        if ($urandom_range(0, 7) == 0) return $urandom_range(60, 200);
        return $urandom_range(0, 24);
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [8:0] got,
                               input logic [8:0] want);
        if (got !== want)
            log_mismatch($sformatf("result %0d %s got %0d want %0d",
                                   results_out, name, got, want));
    endtask

    // drive items from the pending queue
    always @(posedge i_clk) begin
        t_arm_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (send_idle > 0) begin
                send_idle--;
                i_in_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                nxt = req_q.pop_front();
                i_in_valid      <= 1'b1;
                i_req_type      <= nxt.kind;
                i_target_number <= nxt.target;
                i_command_value <= nxt.value;
                i_reading_a     <= nxt.rd[0];
                i_reading_b     <= nxt.rd[1];
                i_reading_c     <= nxt.rd[2];
                i_reading_d     <= nxt.rd[3];
                if (req_q.size() <= CALM_TAIL) begin
                    tail_calm <= 1'b1;
                end else if (send_quiet > 0) begin
                    send_quiet--;
                end else begin
                    send_idle  = $urandom_range(1, 16);
                    send_quiet = quiet_len();
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // throttle the output side; hold off once for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            run_cycles++;
            if (run_cycles == HOLD_START) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (tail_calm) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (stall_quiet > 0) begin
                stall_quiet--;
                i_out_stall <= 1'b0;
            end else begin
                stall_left  = $urandom_range(0, 15);
                stall_quiet = quiet_len();
                i_out_stall <= 1'b1;
            end
        end
    end

    // predict on accept, check on result
    always @(posedge i_clk) begin
        t_arm_req taken;
        t_arm_out want;
        t_arm_out got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                taken.kind   = t_req'(i_req_type);
                taken.target = i_target_number;
                taken.value  = i_command_value;
                taken.rd     = {i_reading_d, i_reading_c, i_reading_b, i_reading_a};
                arm_step(taken, want);
                arm_out_q.push_back(want);
                items_in++;
            end
            if (o_out_valid && !i_out_stall) begin
                got = {o_duty_a, o_duty_b, o_duty_c, o_duty_d, o_duty_changed,
                       o_current_mode, o_report_kind, o_report_value};
                if (arm_out_q.size() == 0) begin
                    log_mismatch($sformatf("result %0d arrived with nothing pending",
                                           results_out));
                end else begin
                    want = arm_out_q.pop_front();
                    check_field("duty_a", got.duty_a, want.duty_a);
                    check_field("duty_b", got.duty_b, want.duty_b);
                    check_field("duty_c", got.duty_c, want.duty_c);
                    check_field("duty_d", got.duty_d, want.duty_d);
                    check_field("duty_changed", got.changed, want.changed);
                    check_field("current_mode", got.mode, want.mode);
                    check_field("report_kind", got.kind, want.kind);
                    check_field("report_value", got.value, want.value);
                end
                results_out++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, arm_out_q.size());
            $display("servo_pose_record_playback_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int run_len;
        int pick;
        int k;
        arm_mode   = MODE_OFF;
        duty_now   = '{default: '0};
        rec_slot   = 0;
        play_slot  = 0;
        pose_count = 0;

        // directed opening
        req_q.push_back(arm_req(REQ_BUTTON, BTN_PLAY, BTN_VAL_SELECT, rand_pose()));
        req_q.push_back(arm_req(REQ_BUTTON, BTN_PLAY, BTN_VAL_PLAY, rand_pose()));
        req_q.push_back(arm_req(REQ_RECORD, 0, 0, rand_pose()));
        req_q.push_back(arm_req(REQ_TICK, 0, 0, rand_pose()));
        req_q.push_back(arm_req(REQ_ANGLE, 1, 90, rand_pose()));
        req_q.push_back(arm_req(REQ_BUTTON, BTN_MANUAL, 255, rand_pose()));
        req_q.push_back(arm_req(REQ_TICK, 0, 0, 32'h00000000));
        req_q.push_back(arm_req(REQ_TICK, 15, 255, 32'hFFFFFFFF));
        req_q.push_back(arm_req(REQ_RECORD, 0, 0, 32'h00FF00FF));
        req_q.push_back(arm_req(REQ_BUTTON, BTN_PLAY, BTN_VAL_PLAY, rand_pose()));
        req_q.push_back(arm_req(REQ_BUTTON, BTN_REMOTE, 170, rand_pose()));
        req_q.push_back(arm_req(REQ_ANGLE, 1, 255, rand_pose()));
        req_q.push_back(arm_req(REQ_ANGLE, 2, 0, rand_pose()));
        req_q.push_back(arm_req(REQ_ANGLE, 3, 149, rand_pose()));
        req_q.push_back(arm_req(REQ_ANGLE, 4, 0, rand_pose()));
        req_q.push_back(arm_req(REQ_ANGLE, 4, 255, rand_pose()));
        req_q.push_back(arm_req(REQ_ANGLE, 15, 255, rand_pose()));
        req_q.push_back(arm_req(REQ_ANGLE, 0, 90, rand_pose()));
        req_q.push_back(arm_req(REQ_ANGLE, 5, 90, rand_pose()));
        req_q.push_back(arm_req(REQ_BUTTON, 9, 0, rand_pose()));
        req_q.push_back(arm_req(REQ_BUTTON, BTN_PLAY, 255, rand_pose()));
        req_q.push_back(arm_req(REQ_RECORD, 0, 0, 32'hFF00FF00));
        req_q.push_back(arm_req(REQ_BUTTON, BTN_PLAY, BTN_VAL_SELECT, rand_pose()));
        req_q.push_back(arm_req(REQ_BUTTON, BTN_PLAY, BTN_VAL_PLAY, rand_pose()));
        req_q.push_back(arm_req(REQ_BUTTON, BTN_PLAY, BTN_VAL_PLAY, rand_pose()));

        // random sessions: mostly enter a mode, then a run of items that suit it; some runs are fully random
        k = req_q.size() + RANDOM_ITEMS;
        while (req_q.size() < k) begin
            run_len = $urandom_range(2, 12);
            pick    = $urandom_range(0, 9);
            if (pick <= 2) begin
                req_q.push_back(arm_req(REQ_BUTTON, BTN_MANUAL, $urandom_range(0, 255),
                                        rand_pose()));
                repeat (run_len)
                    req_q.push_back(arm_req(($urandom_range(0, 3) == 0) ? REQ_RECORD : REQ_TICK,
                                            $urandom_range(0, 15), $urandom_range(0, 255),
                                            rand_pose()));
            end else if (pick <= 4) begin
                req_q.push_back(arm_req(REQ_BUTTON, BTN_REMOTE, $urandom_range(0, 255),
                                        rand_pose()));
                repeat (run_len)
                    req_q.push_back(arm_req(($urandom_range(0, 5) == 0) ? REQ_RECORD : REQ_ANGLE,
                                            ($urandom_range(0, 7) == 0) ?
                                                $urandom_range(0, 15) : $urandom_range(1, 4),
                                            $urandom_range(0, 1) ?
                                                $urandom_range(40, 190) : $urandom_range(0, 255),
                                            rand_pose()));
            end else if (pick <= 7) begin
                req_q.push_back(arm_req(REQ_BUTTON, BTN_PLAY, BTN_VAL_SELECT, rand_pose()));
                repeat (run_len) begin
                    case ($urandom_range(0, 5))
                        0:       req_q.push_back(arm_req(REQ_RECORD, 0, 0, rand_pose()));
                        1:       req_q.push_back(arm_req(REQ_TICK, 0, 0, rand_pose()));
                        default: req_q.push_back(arm_req(REQ_BUTTON, BTN_PLAY, BTN_VAL_PLAY,
                                                         rand_pose()));
                    endcase
                end
            end else if (pick == 8) begin
                req_q.push_back(arm_req(REQ_BUTTON,
                                        $urandom_range(0, 1) ? BTN_MANUAL : BTN_REMOTE,
                                        $urandom_range(0, 255), rand_pose()));
                repeat (run_len)
                    req_q.push_back(arm_req(REQ_RECORD, $urandom_range(0, 15),
                                            $urandom_range(0, 255), rand_pose()));
            end else begin
                repeat (run_len)
                    req_q.push_back(arm_req(t_req'($urandom_range(0, 3)),
                                            $urandom_range(0, 15), $urandom_range(0, 255),
                                            rand_pose()));
            end
        end
        items_total = req_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_in != items_total || arm_out_q.size() != 0) @(posedge i_clk);
        repeat (END_PAUSE) @(posedge i_clk);

        $display("%0d items sent, %0d results checked, %0d mismatches",
                 items_in, results_out, mismatches);
        $display("%0d poses recorded, %0d replayed, %0d angle moves, %0d tick updates",
                 n_records, n_replays, n_angles, n_ticks);
        if (mismatches == 0) begin
            $display("servo_pose_record_playback_tb passed");
        end else begin
            $display("servo_pose_record_playback_tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/spr_pkg.sv
sv/spr_ctrl.sv
sv/spr_dpath.sv
sv/servo_pose_record_playback.sv
tb/servo_pose_record_playback_tb.sv
